>>> sv/bwol_pkg.sv
`timescale 1ns / 1ps
package bwol_pkg;

	localparam int ANGLE_BITS_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CW                = 34;
	localparam int RADIUS_W          = 16;
	localparam int POS_W             = 24;
	localparam int QB                = RADIUS_W + 30;
	localparam int SUM_W             = 40;

	localparam logic signed [CW-1:0] GAIN_INIT = 34'sd652032874;
	localparam logic [31:0] RANGE_CAP = 32'h8000_0000;

	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_TOWER  = 1'b1;

	localparam logic [31:0] ATAN_TAB [24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	function automatic logic signed [CW-1:0] atan_phase(input int i);
		atan_phase = signed'({{(CW-32){1'b0}}, ATAN_TAB[i]});
	endfunction

endpackage

>>> sv/bwol_cordic.sv
`timescale 1ns / 1ps
module bwol_cordic #(
	parameter int STAGES = bwol_pkg::CORDIC_STAGES_DEF,
	parameter int SIDE_W = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_v,
	input  logic [31:0]                     phase,
	input  logic [SIDE_W-1:0]               side_in,
	output logic                            out_v,
	output logic signed [bwol_pkg::CW-1:0]  cos_o,
	output logic signed [bwol_pkg::CW-1:0]  sin_o,
	output logic [SIDE_W-1:0]               side_out
);
	import bwol_pkg::*;

	logic                 v_s  [STAGES+1];
	logic                 f_s  [STAGES+1];
	logic signed [CW-1:0] x_s  [STAGES+1];
	logic signed [CW-1:0] y_s  [STAGES+1];
	logic signed [CW-1:0] z_s  [STAGES+1];
	logic [SIDE_W-1:0]    sd_s [STAGES+1];

	logic        flip;
	logic [31:0] p;

	// fold into the right half plane
	assign flip = phase[31] ^ phase[30];
	assign p    = flip ? (phase ^ 32'h8000_0000) : phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= GAIN_INIT;
			y_s[0]  <= '0;
			z_s[0]  <= CW'(signed'(p));
			f_s[0]  <= flip;
			sd_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [CW-1:0] xs, ys, at;
		logic                 neg;
		assign xs  = x_s[i] >>> i;
		assign ys  = y_s[i] >>> i;
		assign at  = atan_phase(i);
		assign neg = z_s[i][CW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]  <= neg ? x_s[i] + ys : x_s[i] - ys;
				y_s[i+1]  <= neg ? y_s[i] - xs : y_s[i] + xs;
				z_s[i+1]  <= neg ? z_s[i] + at : z_s[i] - at;
				f_s[i+1]  <= f_s[i];
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign out_v    = v_s[STAGES];
	assign cos_o    = f_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];
	assign sin_o    = f_s[STAGES] ? -y_s[STAGES] : y_s[STAGES];
	assign side_out = sd_s[STAGES];

endmodule

>>> sv/bwol_div.sv
`timescale 1ns / 1ps
module bwol_div #(
	parameter int SIDE_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_v,
	input  logic [bwol_pkg::RADIUS_W-1:0]     radius,
	input  logic [31:0]                       divisor,
	input  logic [SIDE_W-1:0]                 side_in,
	output logic                              out_v,
	output logic [31:0]                       range_o,
	output logic [SIDE_W-1:0]                 side_out
);
	import bwol_pkg::*;

	logic              v_s  [QB+1];
	logic [32:0]       r_s  [QB+1];
	logic [QB-1:0]     q_s  [QB+1];
	logic [31:0]       d_s  [QB+1];
	logic [SIDE_W-1:0] sd_s [QB+1];

	assign v_s[0]  = in_v;
	assign r_s[0]  = '0;
	assign q_s[0]  = '0;
	assign d_s[0]  = divisor;
	assign sd_s[0] = side_in;

	// one quotient bit a stage; dividend is radius shifted up by 30
	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int B = QB - 1 - k;
		logic        dbit;
		logic [32:0] rt;
		logic        ge;
		if (B >= 30) begin : g_rad
			assign dbit = radius[B-30];
		end else begin : g_zero
			assign dbit = 1'b0;
		end
		assign rt = {r_s[k][31:0], dbit};
		assign ge = rt >= {1'b0, d_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1]  <= ge ? rt - {1'b0, d_s[k]} : rt;
				q_s[k+1]  <= {q_s[k][QB-2:0], ge};
				d_s[k+1]  <= d_s[k];
				sd_s[k+1] <= sd_s[k];
			end
		end
	end

	logic [QB-1:0] q;
	logic          over;
	assign q        = q_s[QB];
	assign over     = (|q[QB-1:32]) || (q[31] && (|q[30:0]));
	assign out_v    = v_s[QB];
	assign range_o  = over ? RANGE_CAP : q[31:0];
	assign side_out = sd_s[QB];

endmodule

>>> sv/beacon_width_opponent_locator.sv
`timescale 1ns / 1ps
// Beacon-width opponent locator. Each item is one beacon sighting (edge angles and robot
// pose); it returns the opponent's absolute x/y in Q8.16 metres, saturated, with
// out_of_range set for a zero width or a saturated coordinate. Fully pipelined: one item
// per cycle while the output is not held; three parallel cordics, 46 divider stages (one
// quotient bit each), then multiply, sum and saturate stages. A held output stalls the
// whole pipeline. Registers: beacon_radius at 0x0, tower_offset at 0x4; write them only
// while no item is in flight.
module beacon_width_opponent_locator #(
	parameter int ANGLE_BITS    = bwol_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = bwol_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [2:0]                             paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [15:0]                            rise_angle,
	input  logic [15:0]                            fall_angle,
	input  logic signed [bwol_pkg::POS_W-1:0]      robot_x,
	input  logic signed [bwol_pkg::POS_W-1:0]      robot_y,
	input  logic [15:0]                            robot_heading,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [bwol_pkg::POS_W-1:0]      opponent_x,
	output logic signed [bwol_pkg::POS_W-1:0]      opponent_y,
	output logic                                   out_of_range
);
	import bwol_pkg::*;

	localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
	localparam int SW = 4 * CW + 2 * POS_W + 1;

	logic [15:0] radius_q, tower_q;
	logic        en;

	// config port
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[2])
			REG_RADIUS: prdata = {16'b0, radius_q};
			REG_TOWER:  prdata = {16'b0, tower_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd2621;
			tower_q  <= 16'd5439;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_RADIUS: radius_q <= pwdata[15:0];
				REG_TOWER:  tower_q  <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// phases
	logic [31:0] rise32, fall32, head32, width, half_ph, mid_ph, head_ph, dir_ph;
	logic        zero_w;
	assign rise32  = {16'b0, rise_angle} & AMASK;
	assign fall32  = {16'b0, fall_angle} & AMASK;
	assign head32  = {16'b0, robot_heading} & AMASK;
	assign width   = (fall32 - rise32) & AMASK;
	assign zero_w  = (width == 32'd0);
	assign half_ph = width << (31 - ANGLE_BITS);
	assign mid_ph  = (rise32 << (32 - ANGLE_BITS)) + half_ph;
	assign head_ph = head32 << (32 - ANGLE_BITS);
	assign dir_ph  = head_ph + mid_ph;

	logic                 c_v;
	logic signed [CW-1:0] ss, hc, hs, dc, ds;
	logic                 c_zero;
	logic [POS_W-1:0]     c_rx, c_ry;

	bwol_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_half (
		.clk, .arst_n, .en, .in_v(in_valid), .phase(half_ph), .side_in(zero_w),
		.out_v(c_v), .cos_o(), .sin_o(ss), .side_out(c_zero)
	);

	bwol_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(POS_W)) u_head (
		.clk, .arst_n, .en, .in_v(in_valid), .phase(head_ph), .side_in(robot_x),
		.out_v(), .cos_o(hc), .sin_o(hs), .side_out(c_rx)
	);

	bwol_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(POS_W)) u_dir (
		.clk, .arst_n, .en, .in_v(in_valid), .phase(dir_ph), .side_in(robot_y),
		.out_v(), .cos_o(dc), .sin_o(ds), .side_out(c_ry)
	);

	logic signed [CW-1:0] ss_abs;
	logic [31:0]          divisor;
	assign ss_abs  = ss[CW-1] ? -ss : ss;
	assign divisor = c_zero ? 32'd0 : ss_abs[31:0];

	logic          d_v;
	logic [31:0]   range_w;
	logic [SW-1:0] d_side;

	bwol_div #(.SIDE_W(SW)) u_div (
		.clk, .arst_n, .en, .in_v(c_v), .radius(radius_q), .divisor(divisor),
		.side_in({hc, hs, dc, ds, c_rx, c_ry, c_zero}),
		.out_v(d_v), .range_o(range_w), .side_out(d_side)
	);

	// products
	logic                         v_s1, v_s2, v_s3;
	logic signed [RADIUS_W+CW:0]  tc_s1, ts_s1;
	logic signed [32+CW:0]        rc_s1, rs_s1;
	logic signed [POS_W-1:0]      rx_s1, ry_s1;
	logic                         z_s1;
	logic signed [CW-1:0]         d_hc, d_hs, d_dc, d_ds;
	logic signed [POS_W-1:0]      d_rx, d_ry;
	logic                         d_zero;

	assign {d_hc, d_hs, d_dc, d_ds, d_rx, d_ry, d_zero} = d_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= d_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tc_s1 <= signed'({1'b0, tower_q}) * d_hc;
			ts_s1 <= signed'({1'b0, tower_q}) * d_hs;
			rc_s1 <= signed'({1'b0, range_w}) * d_dc;
			rs_s1 <= signed'({1'b0, range_w}) * d_ds;
			rx_s1 <= d_rx;
			ry_s1 <= d_ry;
			z_s1  <= d_zero;
		end
	end

	// round to Q.16 and sum
	logic signed [RADIUS_W+CW:0] tc_r, ts_r;
	logic signed [32+CW:0]       rc_r, rs_r;
	logic signed [SUM_W-1:0]     sx_s2, sy_s2;
	logic                        z_s2;

	assign tc_r = (tc_s1 + (RADIUS_W+CW+1)'(64'sd536870912)) >>> 30;
	assign ts_r = (ts_s1 + (RADIUS_W+CW+1)'(64'sd536870912)) >>> 30;
	assign rc_r = (rc_s1 + (33+CW)'(64'sd536870912)) >>> 30;
	assign rs_r = (rs_s1 + (33+CW)'(64'sd536870912)) >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2 <= SUM_W'(rx_s1) + SUM_W'(tc_r) + SUM_W'(rc_r);
			sy_s2 <= SUM_W'(ry_s1) + SUM_W'(ts_r) + SUM_W'(rs_r);
			z_s2  <= z_s1;
		end
	end

	// saturate
	localparam logic signed [SUM_W-1:0] PMAX = SUM_W'(64'sd8388607);
	localparam logic signed [SUM_W-1:0] PMIN = SUM_W'(-64'sd8388608);

	logic hix, lox, hiy, loy;
	assign hix = sx_s2 > PMAX;
	assign lox = sx_s2 < PMIN;
	assign hiy = sy_s2 > PMAX;
	assign loy = sy_s2 < PMIN;

	logic signed [POS_W-1:0] ox_s3, oy_s3;
	logic                    f_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s3 <= hix ? PMAX[POS_W-1:0] : lox ? PMIN[POS_W-1:0] : sx_s2[POS_W-1:0];
			oy_s3 <= hiy ? PMAX[POS_W-1:0] : loy ? PMIN[POS_W-1:0] : sy_s2[POS_W-1:0];
			f_s3  <= z_s2 | hix | lox | hiy | loy;
		end
	end

	assign out_valid    = v_s3;
	assign opponent_x   = ox_s3;
	assign opponent_y   = oy_s3;
	assign out_of_range = f_s3;

endmodule
